// File: src/rv32x_pkg.sv
// Shared types and constants of the RV32I-subset instruction executor.
// Holds the transaction payload structs, opcode codes and register indexes.
// No dependencies.
package rv32x_pkg;

  localparam int unsigned XLen      = 32;
  localparam int unsigned PcW       = 11;
  localparam int unsigned StepW     = 20;
  localparam int unsigned RegAddrW  = 5;
  localparam int unsigned TargetW   = 10;
  localparam int unsigned MemIdxW   = 10;
  localparam int unsigned ImmW      = 12;
  localparam int unsigned KindW     = 3;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned OutqDepth = 4;

  localparam logic [StepW-1:0] StepLimitReset = 20'd1000000;

  // Operation codes; the two spare codes execute as a no-op
  typedef enum logic [KindW-1:0] {
    KIND_ADD  = 3'd0,
    KIND_SUB  = 3'd1,
    KIND_ADDI = 3'd2,
    KIND_LW   = 3'd3,
    KIND_SW   = 3'd4,
    KIND_BEQ  = 3'd5
  } kind_e;

  // Configuration register indexes (selected by paddr bit 2)
  localparam logic REG_PROGRAM_LENGTH = 1'b0;
  localparam logic REG_STEP_LIMIT     = 1'b1;

  typedef struct packed {
    logic [KindW-1:0]           kind;
    logic [RegAddrW-1:0]        dest_reg;
    logic [RegAddrW-1:0]        src_reg_a;
    logic [RegAddrW-1:0]        src_reg_b;
    logic signed [ImmW-1:0]     immediate;
    logic [TargetW-1:0]         branch_target;
  } in_item_t;

  typedef struct packed {
    logic [PcW-1:0]             next_pc;
    logic                       reg_write;
    logic [RegAddrW-1:0]        reg_index;
    logic signed [XLen-1:0]     reg_value;
    logic                       mem_write;
    logic [MemIdxW-1:0]         mem_index;
    logic signed [XLen-1:0]     mem_value;
    logic                       halted;
  } out_item_t;

  // One register file write, either committed or in flight
  typedef struct packed {
    logic                en;
    logic [RegAddrW-1:0] addr;
    logic [XLen-1:0]     data;
  } rf_wr_t;

endpackage

// File: src/rv32x_regfile.sv
// 32 x 32-bit register file with registered reads, per-entry valid bits and bypass.
// Depends on rv32x_pkg.
module rv32x_regfile (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [rv32x_pkg::RegAddrW-1:0] rd_addr_a_i,
  input  logic [rv32x_pkg::RegAddrW-1:0] rd_addr_b_i,
  input  rv32x_pkg::rf_wr_t             wr_i,
  input  rv32x_pkg::rf_wr_t             fwd_i,
  output logic [rv32x_pkg::XLen-1:0]    rdata_a_o,
  output logic [rv32x_pkg::XLen-1:0]    rdata_b_o
);
  import rv32x_pkg::*;

  localparam int unsigned Depth = 1 << RegAddrW;

  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_RAM  = 2'd1;
  localparam logic [1:0] SRC_BYP  = 2'd2;

  typedef struct packed {
    logic [1:0]      sel;
    logic [XLen-1:0] data;
  } pick_t;

  logic [XLen-1:0]  mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [XLen-1:0]  raw_a_q, raw_b_q;
  logic [XLen-1:0]  byp_a_q, byp_b_q;
  logic [1:0]       sel_a_q, sel_b_q;
  pick_t            pick_a, pick_b;

  // Choose the freshest source: in-flight result, committing write, array
  function automatic pick_t pick_src(input logic [RegAddrW-1:0] addr,
                                     input rf_wr_t fwd, input rf_wr_t wr,
                                     input logic [Depth-1:0] valid);
    pick_t p;
    p.sel  = SRC_RAM;
    p.data = '0;
    if (addr == '0) begin
      p.sel = SRC_ZERO;
    end else if (fwd.en && fwd.addr == addr) begin
      p.sel  = SRC_BYP;
      p.data = fwd.data;
    end else if (wr.en && wr.addr == addr) begin
      p.sel  = SRC_BYP;
      p.data = wr.data;
    end else if (!valid[addr]) begin
      p.sel = SRC_ZERO;
    end
    return p;
  endfunction

  assign pick_a = pick_src(rd_addr_a_i, fwd_i, wr_i, valid_q);
  assign pick_b = pick_src(rd_addr_b_i, fwd_i, wr_i, valid_q);

  // Array write and registered reads
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      raw_a_q <= mem_q[rd_addr_a_i];
      raw_b_q <= mem_q[rd_addr_b_i];
      byp_a_q <= pick_a.data;
      byp_b_q <= pick_b.data;
    end
  end

  // Valid bits and source selects
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      sel_a_q <= SRC_ZERO;
      sel_b_q <= SRC_ZERO;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        sel_a_q <= pick_a.sel;
        sel_b_q <= pick_b.sel;
      end
    end
  end

  // Steer operands
  always_comb begin
    case (sel_a_q)
      SRC_RAM: rdata_a_o = raw_a_q;
      SRC_BYP: rdata_a_o = byp_a_q;
      default: rdata_a_o = '0;
    endcase
    case (sel_b_q)
      SRC_RAM: rdata_b_o = raw_b_q;
      SRC_BYP: rdata_b_o = byp_b_q;
      default: rdata_b_o = '0;
    endcase
  end

endmodule

// File: src/rv32x_dmem.sv
// Word-addressed data memory with registered read and a clearing sweep after reset.
// Depends on rv32x_pkg.
module rv32x_dmem #(
  parameter int unsigned DATA_WORDS = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               we_i,
  input  logic                               re_i,
  input  logic [$clog2(DATA_WORDS)-1:0]      addr_i,
  input  logic [rv32x_pkg::XLen-1:0]         wdata_i,
  output logic [rv32x_pkg::XLen-1:0]         rdata_o,
  output logic                               busy_o
);
  import rv32x_pkg::*;

  localparam int unsigned AddrW = $clog2(DATA_WORDS);
  localparam logic [AddrW-1:0] LastIdx = AddrW'(DATA_WORDS - 1);

  logic [XLen-1:0]  mem_q [DATA_WORDS];
  logic [XLen-1:0]  rdata_q;
  logic             clr_q;
  logic [AddrW-1:0] clr_idx_q;

  // Sweep every word to zero, one a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == LastIdx) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Single port: clear, store or load
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_idx_q] <= '0;
    end else if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_q;

endmodule

// File: src/rv32x_outq.sv
// Result queue between the writeback stage and the output channel.
// Depends on rv32x_pkg.
module rv32x_outq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rv32x_pkg::out_item_t  push_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rv32x_pkg::out_item_t  out_data_o
);
  import rv32x_pkg::*;

  localparam int unsigned PtrW = $clog2(OutqDepth);

  out_item_t       entry_q [OutqDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;
  logic            pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = entry_q[rd_ptr_q];

  // Store pushed results
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: src/rv32_subset_instruction_executor_core.sv
// Top level of the RV32I-subset instruction executor: operand capture, execute,
// writeback and configuration registers. Depends on rv32x_pkg, rv32x_regfile,
// rv32x_dmem and rv32x_outq.

// The core takes one decoded instruction per cycle while the input is not
// stalled and returns one result transaction per instruction, passed through
// the execute and writeback registers into the result queue. Operands are
// captured from the register file at acceptance, the instruction executes in
// the next cycle and its result is written back in the cycle after that, with
// bypassing so that dependent instructions follow back to back. The one
// exception is a load: an instruction that reads the destination of a load
// directly ahead of it is held while the load is in the execute stage, as the
// data memory read port is registered. Up to four transactions can be in
// flight before the input stalls. After reset the input stalls while the data
// memory is cleared one word per cycle; configuration writes are taken meanwhile.
module rv32_subset_instruction_executor_core #(
  parameter int unsigned DATA_WORDS    = 1024,
  parameter int unsigned PROGRAM_WORDS = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  rv32x_pkg::in_item_t                in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output rv32x_pkg::out_item_t               out_data_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rv32x_pkg::CfgAddrW-1:0]     paddr,
  input  logic [rv32x_pkg::CfgDataW-1:0]     pwdata,
  output logic [rv32x_pkg::CfgDataW-1:0]     prdata,
  output logic                               pready
);
  import rv32x_pkg::*;

  localparam int unsigned AddrW = $clog2(DATA_WORDS);
  localparam int unsigned OccW  = $clog2(OutqDepth + 1);
  localparam logic [XLen-1:0] DataWords = XLen'(DATA_WORDS);
  localparam logic [XLen-1:0] ProgWords = XLen'(PROGRAM_WORDS);

  // Configuration registers
  logic [PcW-1:0]   prog_len_q;
  logic [StepW-1:0] step_limit_q;
  logic             cfg_we;

  // Architectural state
  logic [PcW-1:0]   pc_q, pc_next;
  logic [StepW-1:0] steps_q, steps_next;

  // Pipeline
  logic             in_acc, load_use, mem_busy;
  logic [OccW-1:0]  occ_q;
  logic             out_acc;
  logic             ex_vld_q;
  in_item_t         ex_q;
  logic             wb_vld_q;
  out_item_t        wb_res_q;
  logic             wb_load_q, wb_load_in_q;
  out_item_t        wb_res;

  // Execute signals
  logic [XLen-1:0]  va, vb, imm_ext, addr_sum, alu;
  logic [XLen-1:0]  bound;
  logic             halted_pre, exec, rw_raw, rw, is_load, addr_ok, neg_ok;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] word_idx;
  logic [PcW-1:0]   seq_pc;
  out_item_t        ex_res;
  rf_wr_t           ex_fwd, wb_wr;
  logic [XLen-1:0]  mem_rdata;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q   <= '0;
      step_limit_q <= StepLimitReset;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_PROGRAM_LENGTH: prog_len_q   <= pwdata[PcW-1:0];
        REG_STEP_LIMIT:     step_limit_q <= pwdata[StepW-1:0];
        default:            prog_len_q   <= prog_len_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PROGRAM_LENGTH: prdata = CfgDataW'(prog_len_q);
      REG_STEP_LIMIT:     prdata = CfgDataW'(step_limit_q);
      default:            prdata = '0;
    endcase
  end

  // Input handshake: hold on clear pass, full pipeline or load-use hazard
  assign load_use = ex_vld_q && (ex_q.kind == KIND_LW) && (ex_q.dest_reg != '0) &&
                    ((ex_q.dest_reg == in_data_i.src_reg_a) ||
                     (ex_q.dest_reg == in_data_i.src_reg_b));
  assign in_stall_o = mem_busy || (occ_q == OccW'(OutqDepth)) || load_use;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;

  // Count transactions in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   occ_q <= occ_q + 1'b1;
        2'b01:   occ_q <= occ_q - 1'b1;
        default: occ_q <= occ_q;
      endcase
    end
  end

  // Operand capture
  rv32x_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_acc),
    .rd_addr_a_i (in_data_i.src_reg_a),
    .rd_addr_b_i (in_data_i.src_reg_b),
    .wr_i        (wb_wr),
    .fwd_i       (ex_fwd),
    .rdata_a_o   (va),
    .rdata_b_o   (vb)
  );

  // Execute stage
  always_comb begin
    imm_ext  = {{(XLen-ImmW){ex_q.immediate[ImmW-1]}}, ex_q.immediate};
    addr_sum = va + imm_ext;
    // Truncation toward zero maps byte addresses -1 to -3 onto word 0
    neg_ok   = (&addr_sum[XLen-1:2]) && (|addr_sum[1:0]);
    addr_ok  = addr_sum[XLen-1] ? neg_ok : ({2'b00, addr_sum[XLen-1:2]} < DataWords);
    word_idx = addr_sum[XLen-1] ? '0 : addr_sum[AddrW+1:2];

    bound      = ({21'd0, prog_len_q} < ProgWords) ? {21'd0, prog_len_q} : ProgWords;
    halted_pre = ({21'd0, pc_q} >= bound) || (steps_q >= step_limit_q);
    exec       = ex_vld_q && !halted_pre;

    seq_pc  = pc_q + 1'b1;
    rw_raw  = 1'b0;
    is_load = 1'b0;
    alu     = '0;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    case (ex_q.kind)
      KIND_ADD: begin
        rw_raw = 1'b1;
        alu    = va + vb;
      end
      KIND_SUB: begin
        rw_raw = 1'b1;
        alu    = va - vb;
      end
      KIND_ADDI: begin
        rw_raw = 1'b1;
        alu    = addr_sum;
      end
      KIND_LW: begin
        rw_raw  = 1'b1;
        is_load = 1'b1;
        mem_re  = exec && addr_ok;
      end
      KIND_SW: begin
        mem_we = exec && addr_ok;
      end
      KIND_BEQ: begin
        if (va == vb) begin
          seq_pc = {1'b0, ex_q.branch_target};
        end
      end
      default: begin
        rw_raw = 1'b0;
      end
    endcase
    rw = exec && rw_raw && (ex_q.dest_reg != '0);

    pc_next    = exec ? seq_pc : pc_q;
    steps_next = exec ? steps_q + 1'b1 : steps_q;

    ex_res.next_pc   = pc_next;
    ex_res.reg_write = rw;
    ex_res.reg_index = rw ? ex_q.dest_reg : '0;
    ex_res.reg_value = rw ? alu : '0;
    ex_res.mem_write = mem_we;
    ex_res.mem_index = mem_we ? MemIdxW'(word_idx) : '0;
    ex_res.mem_value = mem_we ? vb : '0;
    ex_res.halted    = ({21'd0, pc_next} >= bound) || (steps_next >= step_limit_q);

    ex_fwd.en   = rw && !is_load;
    ex_fwd.addr = ex_q.dest_reg;
    ex_fwd.data = alu;
  end

  // Data memory
  rv32x_dmem #(
    .DATA_WORDS (DATA_WORDS)
  ) u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (word_idx),
    .wdata_i (vb),
    .rdata_o (mem_rdata),
    .busy_o  (mem_busy)
  );

  // Advance stage valids and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q <= 1'b0;
      wb_vld_q <= 1'b0;
      pc_q     <= '0;
      steps_q  <= '0;
    end else begin
      ex_vld_q <= in_acc;
      wb_vld_q <= ex_vld_q;
      if (ex_vld_q) begin
        pc_q    <= pc_next;
        steps_q <= steps_next;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ex_q <= in_data_i;
    end
    if (ex_vld_q) begin
      wb_res_q     <= ex_res;
      wb_load_q    <= is_load && rw;
      wb_load_in_q <= addr_ok;
    end
  end

  // Writeback: merge load data, commit to register file
  always_comb begin
    wb_res = wb_res_q;
    if (wb_load_q) begin
      wb_res.reg_value = wb_load_in_q ? mem_rdata : '0;
    end
    wb_wr.en   = wb_vld_q && wb_res.reg_write;
    wb_wr.addr = wb_res.reg_index;
    wb_wr.data = wb_res.reg_value;
  end

  rv32x_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (wb_vld_q),
    .push_data_i (wb_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: src/rv32x_checker.sv
// Port-level checks for the RV32I-subset instruction executor, bound to the top.
// Depends on rv32x_pkg and rv32_subset_instruction_executor_core.
module rv32x_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input rv32x_pkg::in_item_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input rv32x_pkg::out_item_t out_data_o
);

  // No result once reset has been seen for a cycle
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result offered during reset");

  // Input held off when reset is released, while the data memory is cleared
  assert property (@(posedge clk_i) $rose(rst_ni) |-> in_stall_o)
    else $error("input accepted before the memory clear pass");

  // A stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A stalled input transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input changed");

endmodule

bind rv32_subset_instruction_executor_core rv32x_checker u_checker (.*);
